// ----- hw/rtl/annealing_move_acceptance_core_assert.svh -----
// Assertion macros for the move-acceptance core checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ANNEALING_MOVE_ACCEPTANCE_CORE_ASSERT_SVH
`define ANNEALING_MOVE_ACCEPTANCE_CORE_ASSERT_SVH

// Same-cycle implication
`define AMAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define AMAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/amac_pkg.sv -----
// Shared constants, types and constant exp tables of the move-acceptance core.
// No dependencies; every RTL module in the project imports this package.
`default_nettype none

package amac_pkg;

  // Sizing
  localparam int INDEX_BITS     = 10;
  localparam int PROB_FRAC_BITS = 24;
  localparam int DATA_BITS      = 32;
  localparam int RAND_BITS      = 31;
  localparam int TFRAC_BITS     = 16;
  localparam int Y_FRAC_BITS    = 23;
  localparam int ROM_SIZE       = 1 << INDEX_BITS;
  localparam int ROM_ROWS       = ROM_SIZE / 32;
  localparam int PROB_BITS      = PROB_FRAC_BITS + 1;
  localparam int PROB_PROD_BITS = 2 * PROB_BITS;
  localparam int PROD_BITS      = 2 * DATA_BITS;
  localparam int NUM_BITS       = DATA_BITS + TFRAC_BITS;
  localparam int LOW_TEST_BITS  = 64;

  // Quotient of the ratio divider: enough fraction bits for the table index
  // and for the linear region, seven integer bits since the ratio stays <= 80
  localparam int QUOT_FRAC_BITS =
    (PROB_FRAC_BITS > Y_FRAC_BITS) ? PROB_FRAC_BITS : Y_FRAC_BITS;
  localparam int QUOT_INT_BITS  = 7;
  localparam int QUOT_BITS      = QUOT_FRAC_BITS + QUOT_INT_BITS;
  localparam int G_BITS         = Y_FRAC_BITS + QUOT_INT_BITS;
  localparam int DIV_PRE_SHIFT  = TFRAC_BITS + QUOT_FRAC_BITS - QUOT_BITS;

  // Random fraction scaling
  localparam int RX_BITS        = RAND_BITS + PROB_FRAC_BITS;
  localparam int RSUM_BITS      =
    ((PROB_FRAC_BITS > RAND_BITS) ? PROB_FRAC_BITS : RAND_BITS) + 1;
  localparam logic [RAND_BITS-1:0] RAND_FULL = {RAND_BITS{1'b1}};

  // Ratio limits
  localparam int LIMIT_HIGH    = 80;
  localparam int LIMIT_LOW_DEN = 10000;

  localparam logic [PROB_BITS-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

  // Configuration register indexes and reset values
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_FACTOR = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TEMPERATURE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GREEDY_MODE = 2'd2;
  localparam logic [DATA_BITS-1:0] TIME_FACTOR_RESET = 32'h0001_0000;
  localparam logic [DATA_BITS-1:0] TEMPERATURE_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [DATA_BITS-1:0] time_factor;
    logic [DATA_BITS-1:0] temperature;
    logic                 greedy_mode;
  } cfg_t;

  // Per-item sideband that rides along the pipeline
  typedef struct packed {
    logic [DATA_BITS-1:0] cost;
    logic [PROB_BITS-1:0] rfrac;
    logic                 decided;
    logic                 early_acc;
    logic                 linear;
  } side_t;

  typedef struct packed {
    logic                 accepted;
    logic [DATA_BITS-1:0] cost;
  } res_t;

  typedef logic [PROB_BITS-1:0] rom_t [ROM_SIZE];

  // Bit-serial 64 by 7 bit division, used only while building the tables
  function automatic logic [63:0] div_small(logic [63:0] num, logic [6:0] den);
    logic [63:0] quo;
    logic [7:0]  rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[6:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-2^e) in Q2.62 by Taylor series in Q3.60
  function automatic logic [63:0] exp_pow2(int e);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'h1000_0000_0000_0000;
    pos  = term;
    neg  = '0;
    for (int n = 1; n < 64; n++) begin
      if (term != '0) begin
        if (e >= 0) begin
          term = div_small(term << e, 7'(n));
        end else begin
          term = div_small(term >> (-e), 7'(n));
        end
        if (n % 2 == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    return (pos - neg) << 2;
  endfunction

  // Q2.62 product, round half up
  function automatic logic [63:0] mul_w(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> 62) + 64'(p[61]);
  endfunction

  // Table k holds exp(-i * 2^(k*INDEX_BITS - 23)) in Q1.PROB_FRAC_BITS
  function automatic rom_t build_rom(int k);
    rom_t        tbl;
    logic [63:0] f;
    logic [63:0] w;
    int          sh;
    sh = 62 - PROB_FRAC_BITS;
    f  = exp_pow2(k * INDEX_BITS - Y_FRAC_BITS);
    w  = 64'h4000_0000_0000_0000;
    for (int hi = 0; hi < ROM_ROWS; hi++) begin
      for (int lo = 0; lo < 32; lo++) begin
        tbl[hi*32 + lo] = PROB_BITS'((w + (64'd1 << (sh - 1))) >> sh);
        w = mul_w(w, f);
      end
    end
    return tbl;
  endfunction

  localparam rom_t ROM_FINE   = build_rom(0);
  localparam rom_t ROM_MID    = build_rom(1);
  localparam rom_t ROM_COARSE = build_rom(2);

endpackage

`default_nettype wire

// ----- hw/rtl/annealing_move_acceptance_core.sv -----
// Metropolis move-acceptance core: one accept/reject decision per item, one item
// per clock sustained while in_stall_o is low. The ratio divider resolves one
// quotient bit per pipeline stage, with QUOT_BITS = max(PROB_FRAC_BITS, 23) + 7
// quotient bits. Three front stages form the weighted cost, the divider forms
// cost/T, three back stages form exp(-x) from three constant tables, and an
// output register with a one-item skid buffer decouples out_stall_i, so
// in_stall_o is a plain register. Zero temperature rejects every negative cost.
// Depends on amac_pkg, amac_front, amac_div and amac_prob.
`default_nettype none

module annealing_move_acceptance_core
  import amac_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic        [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic        [DATA_BITS-1:0]    cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [DATA_BITS-1:0]    wire_delta_i,
  input  logic signed [DATA_BITS-1:0]    time_delta_i,
  input  logic signed [DATA_BITS-1:0]    penalty_delta_i,
  input  logic        [RAND_BITS-1:0]    random_value_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accepted_o,
  output logic signed [DATA_BITS-1:0]    cost_delta_o
);

  // ---------------- configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_factor <= TIME_FACTOR_RESET;
      cfg_q.temperature <= TEMPERATURE_RESET;
      cfg_q.greedy_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIME_FACTOR: cfg_q.time_factor <= cfg_data_i;
        CFG_TEMPERATURE: cfg_q.temperature <= cfg_data_i;
        CFG_GREEDY_MODE: cfg_q.greedy_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline
  // The whole pipe moves while the skid buffer is empty
  logic                 adv;
  logic                 fr_v, dv_v, pr_v;
  logic [DATA_BITS-1:0] fr_mag;
  side_t                fr_side, dv_side, pr_side;
  logic [QUOT_BITS-1:0] dv_quot;
  logic [PROB_BITS-1:0] pr_prob;

  logic skid_v_q, skid_v_d;
  logic out_v_q, out_v_d;
  res_t skid_res_q, skid_res_d;
  res_t out_res_q, out_res_d;

  assign adv        = ~skid_v_q;
  assign in_stall_o = skid_v_q;

  amac_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .cfg_i           (cfg_q),
    .valid_i         (in_valid_i),
    .wire_delta_i    (wire_delta_i),
    .time_delta_i    (time_delta_i),
    .penalty_delta_i (penalty_delta_i),
    .random_value_i  (random_value_i),
    .valid_o         (fr_v),
    .mag_o           (fr_mag),
    .side_o          (fr_side)
  );

  amac_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .temperature_i (cfg_q.temperature),
    .valid_i       (fr_v),
    .mag_i         (fr_mag),
    .side_i        (fr_side),
    .valid_o       (dv_v),
    .quot_o        (dv_quot),
    .side_o        (dv_side)
  );

  amac_prob u_prob (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_v),
    .quot_i  (dv_quot),
    .side_i  (dv_side),
    .valid_o (pr_v),
    .prob_o  (pr_prob),
    .side_o  (pr_side)
  );

  // ---------------- decision and output buffer
  logic arr_v;
  logic out_free;
  res_t arr_res;

  assign arr_v            = pr_v & adv;
  assign arr_res.accepted = pr_side.decided ? pr_side.early_acc : (pr_prob > pr_side.rfrac);
  assign arr_res.cost     = pr_side.cost;
  assign out_free         = ~out_v_q | ~out_stall_i;

  always_comb begin
    out_v_d    = out_v_q;
    out_res_d  = out_res_q;
    skid_v_d   = skid_v_q;
    skid_res_d = skid_res_q;
    if (out_free) begin
      if (skid_v_q) begin
        out_v_d   = 1'b1;
        out_res_d = skid_res_q;
        skid_v_d  = 1'b0;
      end else begin
        out_v_d   = arr_v;
        out_res_d = arr_res;
      end
    end else if (arr_v) begin
      skid_v_d   = 1'b1;
      skid_res_d = arr_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_valid_o  = out_v_q;
  assign accepted_o   = out_res_q.accepted;
  assign cost_delta_o = out_res_q.cost;

endmodule

`default_nettype wire

// ----- hw/rtl/amac_front.sv -----
// Front end: timing weight multiply, cost sum and ratio classification (3 stages).
// Depends on amac_pkg.
`default_nettype none

module amac_front
  import amac_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  cfg_t                        cfg_i,
  input  logic                        valid_i,
  input  logic signed [DATA_BITS-1:0] wire_delta_i,
  input  logic signed [DATA_BITS-1:0] time_delta_i,
  input  logic signed [DATA_BITS-1:0] penalty_delta_i,
  input  logic        [RAND_BITS-1:0] random_value_i,
  output logic                        valid_o,
  output logic        [DATA_BITS-1:0] mag_o,
  output side_t                       side_o
);

  // ---------------- stage A: multiply, greedy cost, random fraction
  logic [DATA_BITS-1:0] wd, td, pd, tmag;
  logic                 tneg;
  logic [RX_BITS-1:0]   rx;
  logic [PROB_FRAC_BITS-1:0] rq0;
  logic [RSUM_BITS-1:0] rsum;

  logic                 a_v_q;
  logic [PROD_BITS-1:0] a_prod_q, a_prod_d;
  logic                 a_tneg_q;
  logic [DATA_BITS-1:0] a_wire_q, a_pen_q, a_gcost_q, a_gcost_d;
  logic [PROB_BITS-1:0] a_rfrac_q, a_rfrac_d;

  assign wd   = wire_delta_i;
  assign td   = time_delta_i;
  assign pd   = penalty_delta_i;
  assign tneg = td[DATA_BITS-1];
  assign tmag = tneg ? (DATA_BITS'(0) - td) : td;

  assign a_prod_d  = PROD_BITS'(cfg_i.time_factor) * PROD_BITS'(tmag);
  assign a_gcost_d = ((td == '0) ? wd : td) + pd;

  // floor(r * 2^P / (2^31-1)): split at bit 31, then one correction
  assign rx        = {random_value_i, {PROB_FRAC_BITS{1'b0}}};
  assign rq0       = rx[RX_BITS-1:RAND_BITS];
  assign rsum      = RSUM_BITS'(rq0) + RSUM_BITS'(rx[RAND_BITS-1:0]);
  assign a_rfrac_d = PROB_BITS'(rq0) + PROB_BITS'(rsum >= RSUM_BITS'(RAND_FULL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv_i) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_prod_q  <= a_prod_d;
      a_tneg_q  <= tneg;
      a_wire_q  <= wd;
      a_pen_q   <= pd;
      a_gcost_q <= a_gcost_d;
      a_rfrac_q <= a_rfrac_d;
    end
  end

  // ---------------- stage B: scaled timing term and cost sum
  logic [DATA_BITS-1:0] scaled, scaled_s;
  logic                 b_v_q;
  logic [DATA_BITS-1:0] b_cost_q, b_cost_d;
  logic [PROB_BITS-1:0] b_rfrac_q;

  assign scaled   = a_prod_q[TFRAC_BITS +: DATA_BITS];
  assign scaled_s = a_tneg_q ? (DATA_BITS'(0) - scaled) : scaled;
  assign b_cost_d = cfg_i.greedy_mode ? a_gcost_q : (a_wire_q + scaled_s + a_pen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (adv_i) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_cost_q  <= b_cost_d;
      b_rfrac_q <= a_rfrac_q;
    end
  end

  // ---------------- stage C: magnitude and ratio range checks
  logic [DATA_BITS-1:0]     mag;
  logic [NUM_BITS-1:0]      num, hi_lim;
  logic [LOW_TEST_BITS-1:0] lo_val;
  logic                     neg, tzero, reject, linear;
  logic                     c_v_q;
  logic [DATA_BITS-1:0]     c_mag_q;
  side_t                    c_side_q, c_side_d;

  assign mag    = DATA_BITS'(0) - b_cost_q;
  assign num    = {mag, {TFRAC_BITS{1'b0}}};
  assign hi_lim = NUM_BITS'(cfg_i.temperature) * NUM_BITS'(LIMIT_HIGH);
  assign lo_val = (LOW_TEST_BITS'(mag) * LOW_TEST_BITS'(LIMIT_LOW_DEN)) << TFRAC_BITS;
  assign neg    = b_cost_q[DATA_BITS-1];
  assign tzero  = (cfg_i.temperature == '0);
  assign reject = (num > hi_lim);
  assign linear = (lo_val < LOW_TEST_BITS'(cfg_i.temperature));

  always_comb begin
    c_side_d.cost      = b_cost_q;
    c_side_d.rfrac     = b_rfrac_q;
    c_side_d.decided   = cfg_i.greedy_mode | ~neg | tzero | reject;
    c_side_d.early_acc = ~neg;
    c_side_d.linear    = linear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (adv_i) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_mag_q  <= mag;
      c_side_q <= c_side_d;
    end
  end

  assign valid_o = c_v_q;
  assign mag_o   = c_mag_q;
  assign side_o  = c_side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/amac_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: (mag * 2^(16+F)) / T.
// Depends on amac_pkg.
`default_nettype none

module amac_div
  import amac_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [DATA_BITS-1:0] temperature_i,
  input  logic                 valid_i,
  input  logic [DATA_BITS-1:0] mag_i,
  input  side_t                side_i,
  output logic                 valid_o,
  output logic [QUOT_BITS-1:0] quot_o,
  output side_t                side_o
);

  logic                 v_q    [QUOT_BITS];
  logic [DATA_BITS-1:0] rem_q  [QUOT_BITS];
  logic [QUOT_BITS-1:0] quo_q  [QUOT_BITS];
  side_t                side_q [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    logic                 v_in;
    logic [DATA_BITS-1:0] rem_in;
    logic [QUOT_BITS-1:0] quo_in;
    side_t                side_in;
    logic [DATA_BITS:0]   trial;
    logic                 take;

    // The dividend's low bits are all zero, so the first stage starts from
    // the top bits and every later stage shifts in a zero.
    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = DATA_BITS'({mag_i, {DIV_PRE_SHIFT{1'b0}}});
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, 1'b0};
    assign take  = (trial >= {1'b0, temperature_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= take ? DATA_BITS'(trial - {1'b0, temperature_i})
                          : trial[DATA_BITS-1:0];
        quo_q[k]  <= {quo_in[QUOT_BITS-2:0], take};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QUOT_BITS-1];
  assign quot_o  = quo_q[QUOT_BITS-1];
  assign side_o  = side_q[QUOT_BITS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/amac_prob.sv -----
// Probability back end: table lookup or linear term, then two Q1.P products.
// Depends on amac_pkg (exp tables and widths).
`default_nettype none

module amac_prob
  import amac_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [QUOT_BITS-1:0] quot_i,
  input  side_t                side_i,
  output logic                 valid_o,
  output logic [PROB_BITS-1:0] prob_o,
  output side_t                side_o
);

  // ---------------- stage E: table reads; linear region rides as a factor
  logic [G_BITS-1:0]     g;
  logic [INDEX_BITS-1:0] idx0, idx1, idx2;
  logic [PROB_BITS-1:0]  lin;
  logic                  e_v_q;
  logic [PROB_BITS-1:0]  e_f2_q, e_f1_q, e_f0_q;
  side_t                 e_side_q;

  assign g    = G_BITS'(quot_i >> (QUOT_FRAC_BITS - Y_FRAC_BITS));
  assign idx0 = INDEX_BITS'(g);
  assign idx1 = INDEX_BITS'(g >> INDEX_BITS);
  assign idx2 = INDEX_BITS'(g >> (2 * INDEX_BITS));
  assign lin  = PROB_ONE - PROB_BITS'(quot_i >> (QUOT_FRAC_BITS - PROB_FRAC_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (adv_i) begin
      e_v_q <= valid_i;
    end
  end

  // A factor of one passes the other operand unchanged through the products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e_f2_q   <= side_i.linear ? lin      : ROM_COARSE[idx2];
      e_f1_q   <= side_i.linear ? PROB_ONE : ROM_MID[idx1];
      e_f0_q   <= side_i.linear ? PROB_ONE : ROM_FINE[idx0];
      e_side_q <= side_i;
    end
  end

  // ---------------- stage F: coarse times mid
  logic [PROB_PROD_BITS-1:0] f_prod;
  logic                      f_v_q;
  logic [PROB_BITS-1:0]      f_p_q, f_f0_q;
  side_t                     f_side_q;

  assign f_prod = PROB_PROD_BITS'(e_f2_q) * PROB_PROD_BITS'(e_f1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (adv_i) begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f_p_q    <= PROB_BITS'(f_prod >> PROB_FRAC_BITS);
      f_f0_q   <= e_f0_q;
      f_side_q <= e_side_q;
    end
  end

  // ---------------- stage G: times fine
  logic [PROB_PROD_BITS-1:0] g_prod;
  logic                      g_v_q;
  logic [PROB_BITS-1:0]      g_p_q;
  side_t                     g_side_q;

  assign g_prod = PROB_PROD_BITS'(f_p_q) * PROB_PROD_BITS'(f_f0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (adv_i) begin
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      g_p_q    <= PROB_BITS'(g_prod >> PROB_FRAC_BITS);
      g_side_q <= f_side_q;
    end
  end

  assign valid_o = g_v_q;
  assign prob_o  = g_p_q;
  assign side_o  = g_side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/amac_checker.sv -----
// Port-level checker for the move-acceptance core, attached by bind.
// Depends on amac_pkg and annealing_move_acceptance_core_assert.svh.
`default_nettype none
`include "annealing_move_acceptance_core_assert.svh"

module amac_checker
  import amac_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_i,
  input logic                        out_valid_i,
  input logic                        out_stall_i,
  input logic                        accepted_i,
  input logic signed [DATA_BITS-1:0] cost_delta_i
);

  // a stalled result stays and holds its value
  `AMAC_ASSERT_NEXT(a_out_valid_held, out_valid_i && out_stall_i, out_valid_i, "result dropped while stalled")
  `AMAC_ASSERT_NEXT(a_out_data_held, out_valid_i && out_stall_i, $stable(cost_delta_i) && $stable(accepted_i), "result changed while stalled")

  // a non-negative cost always accepts, in either mode
  `AMAC_ASSERT_NOW(a_nonneg_accepts, out_valid_i && !cost_delta_i[DATA_BITS-1], accepted_i, "non-negative cost rejected")

  // input back-pressure only follows a stalled result
  `AMAC_ASSERT_NOW(a_stall_cause, $rose(in_stall_i), $past(out_valid_i && out_stall_i), "input stalled without output stall")
  `AMAC_ASSERT_NOW(a_skid_behind_out, in_stall_i, out_valid_i, "skid holds an item while output is empty")

endmodule

bind annealing_move_acceptance_core amac_checker u_amac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .accepted_i   (accepted_o),
  .cost_delta_i (cost_delta_o)
);

`default_nettype wire
